// ===== src/lbp_pkg.sv =====
// shared types and constants for the led blink pattern generator
package lbp_pkg;

    localparam int PAT_WIDTH  = 56;
    localparam int CFG_WIDTH  = 56;
    localparam int DUR_WIDTH  = 16;
    localparam int FLD_WIDTH  = 16;
    localparam int REP_WIDTH  = 8;
    localparam int MODE_WIDTH = 3;
    localparam int IDX_WIDTH  = 3;

    // packed pattern word layout
    localparam int PERIOD_MSB = 55;
    localparam int PERIOD_LSB = 40;
    localparam int ON_MSB     = 39;
    localparam int ON_LSB     = 24;
    localparam int REP_MSB    = 23;
    localparam int REP_LSB    = 16;
    localparam int DELAY_MSB  = 15;
    localparam int DELAY_LSB  = 0;

    localparam logic [MODE_WIDTH-1:0] MODE_MANUAL  = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_SLOWEST = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_NORMAL  = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_FASTEST = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_DOUBLE  = 3'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_TRIPLE  = 3'd5;

    localparam logic [IDX_WIDTH-1:0] CFG_SLOWEST    = 3'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_NORMAL     = 3'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_FASTEST    = 3'd2;
    localparam logic [IDX_WIDTH-1:0] CFG_DOUBLE     = 3'd3;
    localparam logic [IDX_WIDTH-1:0] CFG_TRIPLE     = 3'd4;
    localparam logic [IDX_WIDTH-1:0] CFG_LOCATE_DUR = 3'd5;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_MODE = 2'd1,
        CMD_LOCATE   = 2'd2,
        CMD_SET_LED  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                  cmd;
        logic [MODE_WIDTH-1:0] mode_sel;
        logic                  led_value;
    } t_in_word;

    typedef struct packed {
        logic led_lit;
        logic locating;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic loop_step;
        logic final_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_eval;
        logic loop_end;
        logic loop_hit;
    } t_dp_status;

endpackage

// ===== src/lbp_ctrl.sv =====
// controller state machine: sequences accept, pulse walk, delay check and output load
module lbp_ctrl
    import lbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOP  = 4'b0010,
        S_FINAL = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_load;

    assign w_accept = (r_state == S_IDLE) && i_in_valid;
    // output slot free, or its word leaves this cycle
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_status.go_eval ? S_LOOP : S_EMIT;
                end
            end
            S_LOOP: begin
                if (i_status.loop_end) begin
                    n_state = S_FINAL;
                end else if (i_status.loop_hit) begin
                    n_state = S_EMIT;
                end
            end
            S_FINAL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_cmd.accept     = w_accept;
    assign o_cmd.loop_step  = (r_state == S_LOOP);
    assign o_cmd.final_step = (r_state == S_FINAL);
    assign o_cmd.out_load   = w_load;

    a_short_cmd_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_status.go_eval) |=> (r_state == S_EMIT))
        else $error("word without pattern walk did not go to emit");

    a_walk_end_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP && i_status.loop_end) |=> (r_state == S_FINAL))
        else $error("pulse walk end did not go to delay check");

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |=> (r_state == S_EMIT))
        else $error("delay check did not go to emit");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("loaded word not shown or controller not idle");

endmodule

// ===== src/lbp_dpath.sv =====
// datapath: config registers, mode and counter state, pulse walk and output word register
module lbp_dpath
    import lbp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  t_in_word             i_in_word,
    input  logic                 i_cfg_we,
    input  logic [IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    output t_out_word            o_out_word
);

    localparam int CW = COUNT_WIDTH;

    logic [PAT_WIDTH-1:0]  r_pat [0:4];
    logic [DUR_WIDTH-1:0]  r_locate_dur;

    logic [MODE_WIDTH-1:0] r_cur, n_cur;
    logic [MODE_WIDTH-1:0] r_saved, n_saved;
    logic                  r_locate, n_locate;
    logic [CW-1:0]         r_cycle, n_cycle;
    logic [CW-1:0]         r_loc, n_loc;
    logic                  r_led, n_led;
    logic [CW-1:0]         r_t, n_t;
    logic [REP_WIDTH-1:0]  r_rep, n_rep;
    t_out_word             r_out;

    logic [PAT_WIDTH-1:0]  w_pat;
    logic [CW-1:0]         w_period, w_on, w_delay, w_dur;
    logic [REP_WIDTH-1:0]  w_reps;
    logic [CW-1:0]         w_cyc_inc, w_loc_inc, w_rest;
    logic [MODE_WIDTH-1:0] w_sel_mode;
    logic                  w_go_eval;
    logic                  w_loop_end, w_loop_hit;

    // live pattern of the mode in force
    always_comb begin
        unique case (r_cur)
            MODE_SLOWEST: w_pat = r_pat[0];
            MODE_NORMAL:  w_pat = r_pat[1];
            MODE_FASTEST: w_pat = r_pat[2];
            MODE_DOUBLE:  w_pat = r_pat[3];
            MODE_TRIPLE:  w_pat = r_pat[4];
            default:      w_pat = '0;
        endcase
    end

    assign w_period = {{(CW-FLD_WIDTH){1'b0}}, w_pat[PERIOD_MSB:PERIOD_LSB]};
    assign w_on     = {{(CW-FLD_WIDTH){1'b0}}, w_pat[ON_MSB:ON_LSB]};
    assign w_delay  = {{(CW-FLD_WIDTH){1'b0}}, w_pat[DELAY_MSB:DELAY_LSB]};
    assign w_reps   = w_pat[REP_MSB:REP_LSB];
    assign w_dur    = {{(CW-DUR_WIDTH){1'b0}}, r_locate_dur};

    // saturating increments
    assign w_cyc_inc = (r_cycle == {CW{1'b1}}) ? r_cycle : r_cycle + {{(CW-1){1'b0}}, 1'b1};
    assign w_loc_inc = (r_loc == {CW{1'b1}}) ? r_loc : r_loc + {{(CW-1){1'b0}}, 1'b1};
    assign w_rest    = r_t - w_delay;

    assign w_sel_mode = (i_in_word.mode_sel > MODE_TRIPLE) ? MODE_MANUAL : i_in_word.mode_sel;
    assign w_loop_end = (r_rep == w_reps);
    assign w_loop_hit = (r_t < w_period);

    always_comb begin
        n_cur     = r_cur;
        n_saved   = r_saved;
        n_locate  = r_locate;
        n_cycle   = r_cycle;
        n_loc     = r_loc;
        n_led     = r_led;
        n_t       = r_t;
        n_rep     = r_rep;
        w_go_eval = 1'b0;
        if (i_cmd.accept) begin
            unique case (i_in_word.cmd)
                CMD_TICK: begin
                    if (r_cur != MODE_MANUAL) begin
                        n_cycle = w_cyc_inc;
                        n_loc   = w_loc_inc;
                        // locate over: fall back to the saved mode
                        if (r_locate && (w_loc_inc > w_dur)) begin
                            n_locate = 1'b0;
                            if (r_saved != r_cur) begin
                                n_cur   = r_saved;
                                n_cycle = '0;
                            end
                        end
                        w_go_eval = (n_cur != MODE_MANUAL);
                        n_t       = n_cycle;
                        n_rep     = '0;
                    end
                end
                CMD_SET_MODE: begin
                    if (w_sel_mode != r_cur) begin
                        n_cur    = w_sel_mode;
                        n_locate = 1'b0;
                        n_cycle  = '0;
                    end
                end
                CMD_LOCATE: begin
                    if (!r_locate) begin
                        n_saved = r_cur;
                        if (r_cur != MODE_DOUBLE) begin
                            n_cur   = MODE_DOUBLE;
                            n_cycle = '0;
                        end
                        n_loc    = '0;
                        n_locate = 1'b1;
                    end
                end
                CMD_SET_LED: begin
                    n_led = i_in_word.led_value;
                end
            endcase
        end else if (i_cmd.loop_step) begin
            // one pulse period per cycle
            if (!w_loop_end) begin
                if (w_loop_hit) begin
                    n_led = (r_t < w_on);
                end else begin
                    n_t   = r_t - w_period;
                    n_rep = r_rep + {{(REP_WIDTH-1){1'b0}}, 1'b1};
                end
            end
        end else if (i_cmd.final_step) begin
            if (r_t < w_delay) begin
                n_led = 1'b0;
            end else begin
                // cycle restarts, keeping the overshoot
                n_cycle = w_rest;
                n_led   = (w_rest < w_on);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0]     <= '0;
            r_pat[1]     <= '0;
            r_pat[2]     <= '0;
            r_pat[3]     <= '0;
            r_pat[4]     <= '0;
            r_locate_dur <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLOWEST:    r_pat[0]     <= i_cfg_data[PAT_WIDTH-1:0];
                CFG_NORMAL:     r_pat[1]     <= i_cfg_data[PAT_WIDTH-1:0];
                CFG_FASTEST:    r_pat[2]     <= i_cfg_data[PAT_WIDTH-1:0];
                CFG_DOUBLE:     r_pat[3]     <= i_cfg_data[PAT_WIDTH-1:0];
                CFG_TRIPLE:     r_pat[4]     <= i_cfg_data[PAT_WIDTH-1:0];
                CFG_LOCATE_DUR: r_locate_dur <= i_cfg_data[DUR_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= MODE_MANUAL;
            r_saved  <= MODE_MANUAL;
            r_locate <= 1'b0;
            r_cycle  <= '0;
            r_loc    <= '0;
            r_led    <= 1'b0;
        end else begin
            r_cur    <= n_cur;
            r_saved  <= n_saved;
            r_locate <= n_locate;
            r_cycle  <= n_cycle;
            r_loc    <= n_loc;
            r_led    <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_rep <= n_rep;
        if (i_cmd.out_load) begin
            r_out.led_lit  <= r_led;
            r_out.locating <= r_locate;
        end
    end

    assign o_status.go_eval  = w_go_eval;
    assign o_status.loop_end = w_loop_end;
    assign o_status.loop_hit = w_loop_hit;
    assign o_out_word        = r_out;

    a_locate_is_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locate |-> (r_cur == MODE_DOUBLE))
        else $error("locate active outside double tap mode");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.loop_step |-> (r_rep <= w_reps))
        else $error("pulse walk ran past the repeat count");

    a_manual_no_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.loop_step || i_cmd.final_step) |-> (r_cur != MODE_MANUAL))
        else $error("pattern walk in manual mode");

endmodule

// ===== src/led_blink_pattern_generator.sv =====
// A word that needs no pattern walk goes from accept straight to emit and shows on o_out_valid once loaded.
// A tick in a pattern mode walks the pulses until pulse k (from 0) holds the time, then emits;
// when the walk passes all reps pulses into the dark delay, a delay check comes before emit; the walk
// steps one pulse period per cycle through one subtractor.
// Throughput: one word at a time; the next word is taken once the result is in the output register.
// Reset (synchronous, active low): patterns and duration zero, manual mode, LED off, no word.
module led_blink_pattern_generator
    import lbp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    lbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lbp_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_word (o_out_word)
    );

endmodule

// ===== verif/led_blink_pattern_generator_tb.sv =====
// self-checking testbench for the led blink pattern generator: directed rows, then random words
module led_blink_pattern_generator_tb;
    import lbp_pkg::*;

    localparam int COUNT_WIDTH     = 32;
    localparam int DRAIN_CYCLES    = 300;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int WORDS_PER_PHASE = 108;

    localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 3'd7;
    localparam t_out_word DARK = '{1'b0, 1'b0};
    localparam t_out_word LIT  = '{1'b1, 1'b0};

    typedef enum int {SET_DIRECTED, SET_SMALL, SET_ONES, SET_ZEROS, SET_WIDE} t_cfg_set;
    typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} t_idle;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word known;
    } t_row;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_word             in_word;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_word            out_word;
    logic                 cfg_we;
    logic [IDX_WIDTH-1:0] cfg_idx;
    logic [CFG_WIDTH-1:0] cfg_data;

    int send_pct;
    int recv_pct;
    int mismatches   = 0;
    int results_seen = 0;
    int cycles       = 0;

    // predicted block state
    logic [MODE_WIDTH-1:0]  mode_now;
    logic [MODE_WIDTH-1:0]  mode_saved;
    logic                   locate_on;
    logic [COUNT_WIDTH-1:0] cycle_ms;
    logic [COUNT_WIDTH-1:0] locate_ms;
    logic                   led_on;
    logic [PAT_WIDTH-1:0]   pat_reg [5];
    logic [DUR_WIDTH-1:0]   hold_dur;

    t_out_word led_expected_q [$];

    // period, on, repeats, delay
    logic [PAT_WIDTH-1:0] directed_pat [5] = '{
        {16'd4, 16'd2, 8'd2, 16'd3},
        {16'd3, 16'd1, 8'd1, 16'd2},
        {16'd2, 16'd1, 8'd3, 16'd0},
        {16'd2, 16'd1, 8'd2, 16'd2},
        {16'd2, 16'd1, 8'd3, 16'd4}
    };

    t_row plan [26] = '{
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b1, DARK},
        '{'{CMD_SET_LED,  MODE_MANUAL,  1'b1}, 1'b1, LIT},
        '{'{CMD_TICK,     MODE_UNUSED,  1'b1}, 1'b1, LIT},
        '{'{CMD_SET_MODE, MODE_UNUSED,  1'b0}, 1'b1, LIT},
        '{'{CMD_SET_MODE, MODE_SLOWEST, 1'b0}, 1'b1, LIT},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_SET_LED,  MODE_MANUAL,  1'b0}, 1'b1, DARK},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_LOCATE,   MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_LOCATE,   MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_SET_MODE, MODE_DOUBLE,  1'b0}, 1'b0, DARK},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_SET_MODE, MODE_FASTEST, 1'b0}, 1'b0, DARK},
        '{'{CMD_LOCATE,   MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_SET_MODE, MODE_NORMAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_SET_MODE, MODE_TRIPLE,  1'b0}, 1'b0, DARK},
        '{'{CMD_SET_MODE, MODE_DOUBLE,  1'b0}, 1'b0, DARK},
        '{'{CMD_LOCATE,   MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_SET_MODE, MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_LOCATE,   MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK},
        '{'{CMD_TICK,     MODE_MANUAL,  1'b0}, 1'b0, DARK}
    };

    t_cfg_set phase_set [6] = '{SET_SMALL, SET_ONES, SET_ZEROS, SET_SMALL, SET_WIDE, SET_SMALL};

    led_blink_pattern_generator #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL led_blink_pattern_generator");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_pct);
    end

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic void switch_mode(logic [MODE_WIDTH-1:0] m);
        if (m > MODE_TRIPLE) begin
            m = MODE_MANUAL;
        end
        if (m == mode_now) begin
            return;
        end
        mode_now  = m;
        locate_on = 1'b0;
        cycle_ms  = '0;
    endfunction

    // one millisecond: walk the pulses of the running cycle, then the dark delay
    function automatic void advance_ms();
        logic [PAT_WIDTH-1:0]   pat;
        logic [COUNT_WIDTH-1:0] t;
        logic [COUNT_WIDTH-1:0] period;
        logic [COUNT_WIDTH-1:0] on_ms;
        logic [COUNT_WIDTH-1:0] delay_ms;
        if (mode_now == MODE_MANUAL) begin
            return;
        end
        cycle_ms  = sat_inc(cycle_ms);
        locate_ms = sat_inc(locate_ms);
        if (locate_on && locate_ms > COUNT_WIDTH'(hold_dur)) begin
            locate_on = 1'b0;
            switch_mode(mode_saved);
            if (mode_now == MODE_MANUAL) begin
                return;
            end
        end
        pat      = pat_reg[mode_now - MODE_SLOWEST];
        period   = COUNT_WIDTH'(pat[PERIOD_MSB:PERIOD_LSB]);
        on_ms    = COUNT_WIDTH'(pat[ON_MSB:ON_LSB]);
        delay_ms = COUNT_WIDTH'(pat[DELAY_MSB:DELAY_LSB]);
        t = cycle_ms;
        for (int k = 0; k < int'(pat[REP_MSB:REP_LSB]); k++) begin
            if (t < period) begin
                led_on = (t < on_ms);
                return;
            end
            t = t - period;
        end
        if (t < delay_ms) begin
            led_on = 1'b0;
            return;
        end
        // restart the cycle, keeping the ticks past its end
        t        = t - delay_ms;
        cycle_ms = t;
        led_on   = (t < on_ms);
    endfunction

    function automatic t_out_word led_predict(t_in_word w);
        case (w.cmd)
            CMD_TICK: begin
                advance_ms();
            end
            CMD_SET_MODE: begin
                switch_mode(w.mode_sel);
            end
            CMD_LOCATE: begin
                if (!locate_on) begin
                    mode_saved = mode_now;
                    switch_mode(MODE_DOUBLE);
                    locate_ms = '0;
                    locate_on = 1'b1;
                end
            end
            default: begin
                led_on = w.led_value;
            end
        endcase
        return '{led_on, locate_on};
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("mismatch at result %0d: %s got %0b want %0b", results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (led_expected_q.size() == 0) begin
                report_mismatch("unexpected word, led_lit", out_word.led_lit, 1'b0);
            end else begin
                want = led_expected_q.pop_front();
                if (out_word.led_lit != want.led_lit) begin
                    report_mismatch("led_lit", out_word.led_lit, want.led_lit);
                end
                if (out_word.locating != want.locating) begin
                    report_mismatch("locating", out_word.locating, want.locating);
                end
            end
            results_seen++;
        end
    end

    task automatic set_idle(t_idle m);
        send_pct = (m == IDLE_SEND_LIGHT) ? 15 : (m == IDLE_SEND_HEAVY) ? 82 : 0;
        recv_pct = (m == IDLE_SEND_LIGHT) ? 82 : (m == IDLE_SEND_HEAVY) ? 15 : 0;
    endtask

    task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_LOCATE_DUR) begin
            hold_dur = data[DUR_WIDTH-1:0];
        end else begin
            pat_reg[idx] = data;
        end
    endtask

    task automatic program_regs(t_cfg_set s);
        logic [CFG_WIDTH-1:0] val;
        for (int r = 0; r <= int'(CFG_TRIPLE); r++) begin
            case (s)
                SET_DIRECTED: val = directed_pat[r];
                SET_ONES:     val = '1;
                SET_ZEROS:    val = '0;
                SET_WIDE:     val = CFG_WIDTH'({$urandom, $urandom});
                default: begin
                    val = {16'($urandom_range(6)), 16'($urandom_range(7)),
                           8'($urandom_range(4)), 16'($urandom_range(5))};
                end
            endcase
            write_reg(IDX_WIDTH'(r), val);
        end
        // upper data bits are junk for the duration register
        case (s)
            SET_DIRECTED: val = CFG_WIDTH'(1);
            SET_ONES:     val = '1;
            SET_ZEROS:    val = '0;
            default: begin
                val = {(CFG_WIDTH-DUR_WIDTH)'({$urandom, $urandom}),
                       16'($urandom_range(6))};
            end
        endcase
        write_reg(CFG_LOCATE_DUR, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(t_in_word w, logic typed, t_out_word known);
        t_out_word predicted;
        @(negedge clk);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        predicted = led_predict(w);
        led_expected_q.push_back(typed ? known : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (led_expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        t_in_word w;
        int       pick;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        mode_now     = MODE_MANUAL;
        mode_saved   = MODE_MANUAL;
        locate_on    = 1'b0;
        cycle_ms     = '0;
        locate_ms    = '0;
        led_on       = 1'b0;
        hold_dur     = '0;
        for (int r = 0; r < 5; r++) begin
            pat_reg[r] = '0;
        end
        set_idle(IDLE_SEND_LIGHT);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        program_regs(SET_DIRECTED);
        for (int i = 0; i < $size(plan); i++) begin
            send_word(plan[i].w, plan[i].typed, plan[i].known);
        end
        drain();

        // pattern state carries across phases, so new patterns apply mid-cycle
        for (int p = 0; p < $size(phase_set); p++) begin
            set_idle(t_idle'(p / 2));
            program_regs(phase_set[p]);
            repeat (WORDS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    w.cmd = CMD_TICK;
                end else if (pick < 75) begin
                    w.cmd = CMD_SET_MODE;
                end else if (pick < 85) begin
                    w.cmd = CMD_LOCATE;
                end else begin
                    w.cmd = CMD_SET_LED;
                end
                if ($urandom_range(3) == 0) begin
                    w.mode_sel = MODE_WIDTH'($urandom_range(7));
                end else begin
                    w.mode_sel = MODE_WIDTH'($urandom_range(MODE_TRIPLE, MODE_SLOWEST));
                end
                w.led_value = 1'($urandom_range(1));
                send_word(w, 1'b0, DARK);
            end
            drain();
        end

        if (mismatches == 0 && led_expected_q.size() == 0) begin
            $display("PASS led_blink_pattern_generator");
        end else begin
            $display("FAIL led_blink_pattern_generator");
        end
        $finish;
    end

endmodule

// ===== led_blink_pattern_generator.f =====
src/lbp_pkg.sv
src/lbp_ctrl.sv
src/lbp_dpath.sv
src/led_blink_pattern_generator.sv
verif/led_blink_pattern_generator_tb.sv
